>>> rtl/hcd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and Hilbert-index helpers for the curve distance unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package hcd_pkg;

    // Tile side in cells, and the widths that follow from it.
    localparam int GRID_SIDE = 4;
    localparam int CRD_W     = (GRID_SIDE > 2) ? $clog2(GRID_SIDE) : 1;
    localparam int IDX_W     = $clog2(GRID_SIDE * GRID_SIDE);
    localparam int HALF_N    = $clog2(GRID_SIDE + 1) - 1;

    // Fixed field widths.
    localparam int FRAC_W = 16;
    localparam int RAD_W  = 2 * FRAC_W;
    localparam int ROOT_W = FRAC_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int OUT_W  = 4;

    // Q0.16 value of the cell center.
    localparam logic [FRAC_W-1:0] CENTER = 16'h8000;

    // Link mask bit positions.
    localparam int LNK_COL_POS = 0;
    localparam int LNK_COL_NEG = 1;
    localparam int LNK_ROW_POS = 2;
    localparam int LNK_ROW_NEG = 3;

    // Data that rides alongside the square root.
    typedef struct packed {
        logic [FRAC_W-1:0] aec;
        logic [FRAC_W-1:0] aer;
        logic [3:0]        arm;
        logic [OUT_W-1:0]  idx;
        logic [OUT_W-1:0]  mask;
    } t_side;

    // Working state of the digit-by-digit square root.
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_root;

    // Standard xy2d rule, halving from GRID_SIDE / 2 down to 1.
    function automatic logic [IDX_W-1:0] hilbert_index(
        input logic [CRD_W-1:0] col,
        input logic [CRD_W-1:0] row
    );
        logic [CRD_W-1:0] c;
        logic [CRD_W-1:0] r;
        logic [CRD_W-1:0] t;
        logic [CRD_W-1:0] h;
        logic [IDX_W+1:0] hh;
        logic [IDX_W-1:0] d;
        logic             bx;
        logic             by;
        logic [1:0]       q;
        c = col;
        r = row;
        d = '0;
        for (int i = 0; i < HALF_N; i++) begin
            h  = CRD_W'(GRID_SIDE >> (i + 1));
            bx = |(c & h);
            by = |(r & h);
            q  = {bx, bx ^ by};
            hh = (IDX_W + 2)'(h) * (IDX_W + 2)'(h);
            d  = d + IDX_W'(hh * (IDX_W + 2)'(q));
            if (!by) begin
                if (bx) begin
                    c = CRD_W'(GRID_SIDE - 1) - c;
                    r = CRD_W'(GRID_SIDE - 1) - r;
                end
                t = c;
                c = r;
                r = t;
            end
        end
        return d;
    endfunction

    // Two curve indices are joined when they differ by exactly one.
    function automatic logic joined(
        input logic [IDX_W-1:0] a,
        input logic [IDX_W-1:0] b
    );
        logic [IDX_W:0] ax;
        logic [IDX_W:0] bx;
        ax = {1'b0, a};
        bx = {1'b0, b};
        return (bx == ax + 1'b1) || (bx + 1'b1 == ax);
    endfunction

endpackage

>>> rtl/hcd_front.sv
`timescale 1ns / 1ps
// Input stage: center offsets, Hilbert index of the cell and its neighbors, link mask.
// Depends on hcd_pkg.
module hcd_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cell_col,
    input  logic [1:0]                 i_cell_row,
    input  logic [hcd_pkg::FRAC_W-1:0] i_frac_col,
    input  logic [hcd_pkg::FRAC_W-1:0] i_frac_row,
    output logic                       o_valid,
    input  logic                       i_ready,
    output hcd_pkg::t_side             o_side
);

    logic                          r_valid;
    hcd_pkg::t_side                r_side;
    hcd_pkg::t_side                n_side;
    logic [hcd_pkg::CRD_W+1:0]     col_x;
    logic [hcd_pkg::CRD_W+1:0]     row_x;
    logic [hcd_pkg::CRD_W-1:0]     col_s;
    logic [hcd_pkg::CRD_W-1:0]     row_s;
    logic [hcd_pkg::IDX_W-1:0]     d0;
    logic [hcd_pkg::IDX_W+3:0]     d0_x;
    logic [3:0]                    in_tile;
    logic [3:0]                    link;
    logic                          ec_pos;
    logic                          ec_neg;
    logic                          er_pos;
    logic                          er_neg;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_side  = r_side;

    // Saturate coordinates into the tile.
    always_comb begin
        col_x = (hcd_pkg::CRD_W + 2)'(i_cell_col);
        row_x = (hcd_pkg::CRD_W + 2)'(i_cell_row);
        col_s = (col_x >= (hcd_pkg::CRD_W + 2)'(hcd_pkg::GRID_SIDE))
              ? hcd_pkg::CRD_W'(hcd_pkg::GRID_SIDE - 1) : hcd_pkg::CRD_W'(col_x);
        row_s = (row_x >= (hcd_pkg::CRD_W + 2)'(hcd_pkg::GRID_SIDE))
              ? hcd_pkg::CRD_W'(hcd_pkg::GRID_SIDE - 1) : hcd_pkg::CRD_W'(row_x);
    end

    // Curve index of the cell and the neighbors that it is joined to.
    always_comb begin
        d0   = hcd_pkg::hilbert_index(col_s, row_s);
        d0_x = (hcd_pkg::IDX_W + 4)'(d0);
        in_tile[hcd_pkg::LNK_COL_POS] = col_s != hcd_pkg::CRD_W'(hcd_pkg::GRID_SIDE - 1);
        in_tile[hcd_pkg::LNK_COL_NEG] = col_s != '0;
        in_tile[hcd_pkg::LNK_ROW_POS] = row_s != hcd_pkg::CRD_W'(hcd_pkg::GRID_SIDE - 1);
        in_tile[hcd_pkg::LNK_ROW_NEG] = row_s != '0;
        link[hcd_pkg::LNK_COL_POS] = in_tile[hcd_pkg::LNK_COL_POS]
            && hcd_pkg::joined(d0, hcd_pkg::hilbert_index(col_s + 1'b1, row_s));
        link[hcd_pkg::LNK_COL_NEG] = in_tile[hcd_pkg::LNK_COL_NEG]
            && hcd_pkg::joined(d0, hcd_pkg::hilbert_index(col_s - 1'b1, row_s));
        link[hcd_pkg::LNK_ROW_POS] = in_tile[hcd_pkg::LNK_ROW_POS]
            && hcd_pkg::joined(d0, hcd_pkg::hilbert_index(col_s, row_s + 1'b1));
        link[hcd_pkg::LNK_ROW_NEG] = in_tile[hcd_pkg::LNK_ROW_NEG]
            && hcd_pkg::joined(d0, hcd_pkg::hilbert_index(col_s, row_s - 1'b1));
    end

    // Offsets from the center, their magnitudes and which arms face the point.
    always_comb begin
        ec_pos = i_frac_col[hcd_pkg::FRAC_W-1] && |i_frac_col[hcd_pkg::FRAC_W-2:0];
        ec_neg = !i_frac_col[hcd_pkg::FRAC_W-1];
        er_pos = i_frac_row[hcd_pkg::FRAC_W-1] && |i_frac_row[hcd_pkg::FRAC_W-2:0];
        er_neg = !i_frac_row[hcd_pkg::FRAC_W-1];
        n_side.aec  = i_frac_col[hcd_pkg::FRAC_W-1]
                    ? {1'b0, i_frac_col[hcd_pkg::FRAC_W-2:0]}
                    : hcd_pkg::CENTER - i_frac_col;
        n_side.aer  = i_frac_row[hcd_pkg::FRAC_W-1]
                    ? {1'b0, i_frac_row[hcd_pkg::FRAC_W-2:0]}
                    : hcd_pkg::CENTER - i_frac_row;
        n_side.arm  = link & {er_neg, er_pos, ec_neg, ec_pos};
        n_side.idx  = d0_x[3:0];
        n_side.mask = link;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= n_side;
        end
    end

endmodule

>>> rtl/hcd_square.sv
`timescale 1ns / 1ps
// Two-stage sum of squares that seeds the square root chain.
// Depends on hcd_pkg.
module hcd_square (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hcd_pkg::t_side i_side,
    output logic           o_valid,
    input  logic           i_ready,
    output hcd_pkg::t_side o_side,
    output hcd_pkg::t_root o_root
);

    logic                      r_valid_mul;
    logic                      r_valid_sum;
    logic                      rdy_mul;
    logic                      rdy_sum;
    logic [hcd_pkg::RAD_W-1:0] r_sq_col;
    logic [hcd_pkg::RAD_W-1:0] r_sq_row;
    hcd_pkg::t_side            r_side_mul;
    hcd_pkg::t_side            r_side_sum;
    hcd_pkg::t_root            r_root;
    hcd_pkg::t_root            n_root;

    assign rdy_sum = !r_valid_sum || i_ready;
    assign rdy_mul = !r_valid_mul || rdy_sum;
    assign o_ready = rdy_mul;
    assign o_valid = r_valid_sum;
    assign o_side  = r_side_sum;
    assign o_root  = r_root;

    // The sum of two squares of at most 2^15 never exceeds 2^31.
    always_comb begin
        n_root.rad  = r_sq_col + r_sq_row;
        n_root.rem  = '0;
        n_root.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mul <= 1'b0;
            r_valid_sum <= 1'b0;
        end else begin
            if (rdy_mul) begin
                r_valid_mul <= i_valid;
            end
            if (rdy_sum) begin
                r_valid_sum <= r_valid_mul;
            end
        end
    end

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (rdy_mul && i_valid) begin
            r_sq_col   <= i_side.aec * i_side.aec;
            r_sq_row   <= i_side.aer * i_side.aer;
            r_side_mul <= i_side;
        end
    end

    // Add stage.
    always_ff @(posedge i_clk) begin
        if (rdy_sum && r_valid_mul) begin
            r_root     <= n_root;
            r_side_sum <= r_side_mul;
        end
    end

endmodule

>>> rtl/hcd_cell.sv
`timescale 1ns / 1ps
// One cell of the square root chain: settles one result bit per cell.
// Depends on hcd_pkg.
module hcd_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hcd_pkg::t_side i_side,
    input  hcd_pkg::t_root i_root,
    output logic           o_valid,
    input  logic           i_ready,
    output hcd_pkg::t_side o_side,
    output hcd_pkg::t_root o_root
);

    logic                      r_valid;
    hcd_pkg::t_side            r_side;
    hcd_pkg::t_root            r_root;
    hcd_pkg::t_root            n_root;
    logic [hcd_pkg::REM_W+1:0] rem_x;
    logic [hcd_pkg::REM_W+1:0] trial;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_root  = r_root;

    // Bring down the next two radicand bits and try a one in the root.
    always_comb begin
        rem_x = {i_root.rem, i_root.rad[hcd_pkg::RAD_W-1 -: 2]};
        trial = {1'b0, i_root.root, 2'b01};
        n_root.rad = {i_root.rad[hcd_pkg::RAD_W-3:0], 2'b00};
        if (rem_x >= trial) begin
            n_root.rem  = hcd_pkg::REM_W'(rem_x - trial);
            n_root.root = {i_root.root[hcd_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            n_root.rem  = hcd_pkg::REM_W'(rem_x);
            n_root.root = {i_root.root[hcd_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_side <= i_side;
            r_root <= n_root;
        end
    end

endmodule

>>> rtl/hcd_pick.sv
`timescale 1ns / 1ps
// Output stage: picks the nearest of the center and the arms facing the point.
// Depends on hcd_pkg.
module hcd_pick (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  hcd_pkg::t_side             i_side,
    input  hcd_pkg::t_root             i_root,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hcd_pkg::FRAC_W-1:0] o_curve_distance,
    output logic [hcd_pkg::OUT_W-1:0]  o_curve_index,
    output logic [hcd_pkg::OUT_W-1:0]  o_link_mask
);

    logic                       r_valid;
    logic [hcd_pkg::FRAC_W-1:0] r_dist;
    logic [hcd_pkg::OUT_W-1:0]  r_idx;
    logic [hcd_pkg::OUT_W-1:0]  r_mask;
    logic [hcd_pkg::FRAC_W-1:0] n_dist;
    logic                       use_col_arm;
    logic                       use_row_arm;

    assign o_ready          = !r_valid || i_ready;
    assign o_valid          = r_valid;
    assign o_curve_distance = r_dist;
    assign o_curve_index    = r_idx;
    assign o_link_mask      = r_mask;

    // A column arm measures the row offset and a row arm the column offset.
    always_comb begin
        use_col_arm = i_side.arm[hcd_pkg::LNK_COL_POS] || i_side.arm[hcd_pkg::LNK_COL_NEG];
        use_row_arm = i_side.arm[hcd_pkg::LNK_ROW_POS] || i_side.arm[hcd_pkg::LNK_ROW_NEG];
        n_dist = i_root.root;
        if (use_col_arm && i_side.aer < n_dist) begin
            n_dist = i_side.aer;
        end
        if (use_row_arm && i_side.aec < n_dist) begin
            n_dist = i_side.aec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_dist <= n_dist;
            r_idx  <= i_side.idx;
            r_mask <= i_side.mask;
        end
    end

endmodule

>>> rtl/hilbert_cell_carve_distance_unit.sv
`timescale 1ns / 1ps
// Hilbert cell carve distance unit: top level, a pipeline with a row of root cells before the output stage.
// From an input transfer to the result an item passes the front stage, the multiply and
// add stages of the sum of squares, 16 square root cells (one result bit each) and the output register.
// Throughput is one item per cycle while results are taken; every stage stalls only when the stage after it is full.
// Reset (synchronous, active low) empties every stage; the block holds no other state.
module hilbert_cell_carve_distance_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_cell_col,
    input  logic [1:0]                 i_cell_row,
    input  logic [hcd_pkg::FRAC_W-1:0] i_frac_col,
    input  logic [hcd_pkg::FRAC_W-1:0] i_frac_row,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [hcd_pkg::FRAC_W-1:0] o_curve_distance,
    output logic [hcd_pkg::OUT_W-1:0]  o_curve_index,
    output logic [hcd_pkg::OUT_W-1:0]  o_link_mask
);

    localparam int NUM_CELLS = hcd_pkg::ROOT_W;

    logic           front_valid;
    logic           front_ready;
    hcd_pkg::t_side front_side;

    logic           chain_valid [NUM_CELLS+1];
    logic           chain_ready [NUM_CELLS+1];
    hcd_pkg::t_side chain_side  [NUM_CELLS+1];
    hcd_pkg::t_root chain_root  [NUM_CELLS+1];

    // Offsets, curve index and links.
    hcd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_cell_col (i_cell_col),
        .i_cell_row (i_cell_row),
        .i_frac_col (i_frac_col),
        .i_frac_row (i_frac_row),
        .o_valid    (front_valid),
        .i_ready    (front_ready),
        .o_side     (front_side)
    );

    // Sum of squares feeds the head of the chain.
    hcd_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_side  (front_side),
        .o_valid (chain_valid[0]),
        .i_ready (chain_ready[0]),
        .o_side  (chain_side[0]),
        .o_root  (chain_root[0])
    );

    // Row of square root cells, each passing its partial root to the next.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        hcd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .o_ready (chain_ready[g]),
            .i_side  (chain_side[g]),
            .i_root  (chain_root[g]),
            .o_valid (chain_valid[g+1]),
            .i_ready (chain_ready[g+1]),
            .o_side  (chain_side[g+1]),
            .o_root  (chain_root[g+1])
        );
    end

    // Nearest candidate and output register.
    hcd_pick u_pick (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (chain_valid[NUM_CELLS]),
        .o_ready          (chain_ready[NUM_CELLS]),
        .i_side           (chain_side[NUM_CELLS]),
        .i_root           (chain_root[NUM_CELLS]),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_curve_distance (o_curve_distance),
        .o_curve_index    (o_curve_index),
        .o_link_mask      (o_link_mask)
    );

    // Every cell on the curve is joined to one or two neighbors.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($countones(o_link_mask) == 1 || $countones(o_link_mask) == 2))
        else $error("link mask does not hold one or two joined neighbors");

    // The distance never exceeds the half diagonal of a cell.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_curve_distance <= 16'd46340)
        else $error("curve distance beyond the cell half diagonal");

    // Input back-pressure can only come from a full pipeline stalled at the output.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while the output side is free");

    // Nothing emerges from an empty pipeline right after reset.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_valid)
        else $error("result presented directly after reset");

endmodule

>>> bench/hilbert_cell_carve_distance_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Hilbert cell carve distance unit.
// Depends on rtl/hcd_pkg.sv and rtl/hilbert_cell_carve_distance_unit.sv.
module hilbert_cell_carve_distance_unit_tb;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned MAX_GAP = 40;
    localparam int unsigned RANDOM_PER_PHASE = 400;

    // One expected result of the unit.
    typedef struct packed {
        logic [hcd_pkg::FRAC_W-1:0] distance;
        logic [hcd_pkg::OUT_W-1:0]  index;
        logic [hcd_pkg::OUT_W-1:0]  links;
    } t_carve_result;

    // Computes the carve distance of every accepted transfer and checks the results in order.
    class t_carve_scoreboard;
        t_carve_result pending_q[$];
        int unsigned   errors;

        function new();
            errors = 0;
        endfunction

        // Position of a cell along the curve, by repeated quadrant folding.
        function int unsigned curve_position(int unsigned col, int unsigned row);
            int unsigned pos;
            int unsigned span;
            int unsigned qx;
            int unsigned qy;
            int unsigned swap;
            pos = 0;
            for (span = hcd_pkg::GRID_SIDE / 2; span > 0; span = span / 2) begin
                qx = ((col & span) != 0) ? 1 : 0;
                qy = ((row & span) != 0) ? 1 : 0;
                pos += span * span * ((3 * qx) ^ qy);
                if (qy == 0) begin
                    if (qx != 0) begin
                        col = hcd_pkg::GRID_SIDE - 1 - col;
                        row = hcd_pkg::GRID_SIDE - 1 - row;
                    end
                    swap = col;
                    col  = row;
                    row  = swap;
                end
            end
            return pos;
        endfunction

        // Largest integer whose square does not exceed the argument.
        function int unsigned floor_root(longint unsigned v);
            longint unsigned lo;
            longint unsigned hi;
            longint unsigned mid;
            lo = 0;
            hi = 65536;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid <= v) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
            return int'(lo);
        endfunction

        function bit adjacent(int unsigned a, int unsigned b);
            return (b == a + 1) || (a == b + 1);
        endfunction

        // Works out the result of one accepted input transfer.
        function void note_input(logic [1:0] cell_col, logic [1:0] cell_row,
                                 logic [15:0] frac_col, logic [15:0] frac_row);
            int unsigned   col;
            int unsigned   row;
            int            ec;
            int            er;
            int unsigned   aec;
            int unsigned   aer;
            int unsigned   here;
            int unsigned   best;
            logic [3:0]    links;
            t_carve_result res;
            col = cell_col;
            row = cell_row;
            if (col >= hcd_pkg::GRID_SIDE) begin
                col = hcd_pkg::GRID_SIDE - 1;
            end
            if (row >= hcd_pkg::GRID_SIDE) begin
                row = hcd_pkg::GRID_SIDE - 1;
            end
            ec    = int'(frac_col) - 32768;
            er    = int'(frac_row) - 32768;
            aec   = (ec < 0) ? -ec : ec;
            aer   = (er < 0) ? -er : er;
            here  = curve_position(col, row);
            best  = floor_root(longint'(aec) * aec + longint'(aer) * aer);
            links = '0;

            // Arms toward joined neighbors; an arm only counts on the point's side.
            if (col + 1 < hcd_pkg::GRID_SIDE && adjacent(here, curve_position(col + 1, row))) begin
                links[hcd_pkg::LNK_COL_POS] = 1'b1;
                if (ec > 0 && aer < best) best = aer;
            end
            if (col > 0 && adjacent(here, curve_position(col - 1, row))) begin
                links[hcd_pkg::LNK_COL_NEG] = 1'b1;
                if (ec < 0 && aer < best) best = aer;
            end
            if (row + 1 < hcd_pkg::GRID_SIDE && adjacent(here, curve_position(col, row + 1))) begin
                links[hcd_pkg::LNK_ROW_POS] = 1'b1;
                if (er > 0 && aec < best) best = aec;
            end
            if (row > 0 && adjacent(here, curve_position(col, row - 1))) begin
                links[hcd_pkg::LNK_ROW_NEG] = 1'b1;
                if (er < 0 && aec < best) best = aec;
            end

            res.distance = best[15:0];
            res.index    = here[3:0];
            res.links    = links;
            pending_q.push_back(res);
        endfunction

        // Compares one output transfer with the oldest expectation.
        function void check_result(logic [15:0] distance, logic [3:0] index, logic [3:0] links);
            t_carve_result exp_res;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result: distance %0d index %0d links %b",
                         $time, distance, index, links);
                errors++;
                return;
            end
            exp_res = pending_q.pop_front();
            if (distance !== exp_res.distance) begin
                $display("%0t: curve_distance expected %0d actual %0d",
                         $time, exp_res.distance, distance);
                errors++;
            end
            if (index !== exp_res.index) begin
                $display("%0t: curve_index expected %0d actual %0d",
                         $time, exp_res.index, index);
                errors++;
            end
            if (links !== exp_res.links) begin
                $display("%0t: link_mask expected %b actual %b",
                         $time, exp_res.links, links);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return pending_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_ready;
    logic [1:0]                 i_cell_col = '0;
    logic [1:0]                 i_cell_row = '0;
    logic [hcd_pkg::FRAC_W-1:0] i_frac_col = '0;
    logic [hcd_pkg::FRAC_W-1:0] i_frac_row = '0;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [hcd_pkg::FRAC_W-1:0] o_curve_distance;
    logic [hcd_pkg::OUT_W-1:0]  o_curve_index;
    logic [hcd_pkg::OUT_W-1:0]  o_link_mask;

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    t_carve_scoreboard sb = new();

    hilbert_cell_carve_distance_unit i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_cell_col       (i_cell_col),
        .i_cell_row       (i_cell_row),
        .i_frac_col       (i_frac_col),
        .i_frac_row       (i_frac_row),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_curve_distance (o_curve_distance),
        .o_curve_index    (o_curve_index),
        .o_link_mask      (o_link_mask)
    );

    always #5 i_clk = ~i_clk;

    // Result side: check each output transfer, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_curve_distance, o_curve_index, o_link_mask);
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: ends the run when no transfer happens for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // Offers one item, after an optional idle gap, and returns at its transfer edge.
    task automatic send_item(input logic [1:0] col, input logic [1:0] row,
                             input logic [15:0] fc, input logic [15:0] fr);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cell_col <= col;
        i_cell_row <= row;
        i_frac_col <= fc;
        i_frac_row <= fr;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(col, row, fc, fr);
    endtask

    // Fraction with a bias toward the center, the center lines and the extremes.
    function automatic logic [15:0] random_frac();
        logic [15:0] edges [7] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                   16'h8001, 16'hFFFE, 16'hFFFF};
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 55) return 16'($urandom());
        if (pick < 75) return 16'(32768 + $urandom_range(64) - 32);
        if (pick < 85) return 16'h8000;
        return edges[$urandom_range(6)];
    endfunction

    initial begin : stimulus
        logic [15:0] corners [8];
        int unsigned k;
        corners = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                    16'h8001, 16'h4000, 16'hC000, 16'h0001};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase

            if (phase == 0) begin
                // Every cell once, with fractions at the edges and around the center.
                for (k = 0; k < 16; k++) begin
                    send_item(k[1:0], k[3:2], corners[k % 8], corners[(k * 5 + 2) % 8]);
                end
                // Point on the center, points on the center lines, and the far corners.
                send_item(2'd1, 2'd1, 16'h8000, 16'h8000);
                send_item(2'd1, 2'd1, 16'h8000, 16'hFFFF);
                send_item(2'd1, 2'd1, 16'h8000, 16'h0000);
                send_item(2'd1, 2'd2, 16'hFFFF, 16'h8000);
                send_item(2'd1, 2'd2, 16'h0000, 16'h8000);
                send_item(2'd2, 2'd3, 16'h0000, 16'h0000);
                send_item(2'd3, 2'd0, 16'hFFFF, 16'hFFFF);
            end

            for (k = 0; k < RANDOM_PER_PHASE; k++) begin
                send_item(2'($urandom()), 2'($urandom()), random_frac(), random_frac());
            end
        end
        i_valid <= 1'b0;

        // Let every result come out, then watch a little longer for extras.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
